FILE: rtl/rlec_pkg.sv
// Shared types and constants of the run-length escape codec.
// Used by every module of the block; depends on nothing.
package rlec_pkg;

	// Escape and digit characters of the coded stream
	localparam logic [7:0] EscChar   = 8'h24;
	localparam logic [7:0] DigitZero = 8'h30;
	localparam logic [7:0] DigitNine = 8'h39;
	// A run of this many repeats closes as escape, '9', byte
	localparam logic [3:0] RunLimit  = 4'd10;
	localparam logic [3:0] FullRunDigit = 4'd9;

	// Command queue between front and back; depth is a power of two
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef enum logic {
		MODE_COMPRESS   = 1'b0,
		MODE_DECOMPRESS = 1'b1
	} mode_t;

	typedef enum logic {
		CMD_LIST   = 1'b0,	// emit byte0..byte(cnt-1)
		CMD_REPEAT = 1'b1	// emit byte0 cnt times
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [3:0]  cnt;
	} cmd_t;

	// Head of the command queue as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

FILE: rtl/rle_dollar_escape_codec.sv
// Top level of the run-length escape codec: front end, command queue,
// back end. Depends on rlec_pkg, rlec_front, rlec_queue and rlec_back.
// Usage:
//   Input channel in_valid/in_stall carries data_byte and end_of_stream;
//   a request is taken at a clock edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries out_byte and run_last;
//   run_last marks the final byte produced by one input request.
//   cfg_we/cfg_wdata write the mode bit (0 compress, 1 decompress); write
//   it only while no output is pending.
// Timing:
//   The front end classifies one request per cycle, while the queue has room,
//   into at most one command and pushes it into a four-entry queue; the back
//   end drains one output byte per cycle while out_stall is low. A request
//   yields up to three bytes when compressing, up to nine on a decoded run,
//   none for an escape or a repeat that only extends a run. Commands are held
//   in the queue, bytes in the output register; the back end sets the rate.
// Reset and stall:
//   arst_n clears mode, stream state, queue and output register; a request
//   with end_of_stream also returns the stream state to reset after flushing.
//   out_stall holds the output register; the queue absorbs requests until full.
module rle_dollar_escape_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_last
);

	logic              accept;
	logic              cmd_push;
	rlec_pkg::cmd_t    cmd;
	logic              q_full;
	logic              q_pop;
	rlec_pkg::q_head_t q_head;

	// Advance the front end whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	rlec_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.cmd_push      (cmd_push),
		.cmd           (cmd)
	);

	rlec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (q_pop),
		.full     (q_full),
		.head     (q_head)
	);

	rlec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

FILE: rtl/rlec_front.sv
// Front end of the run-length escape codec: mode register, stream state
// and classification of each accepted byte into at most one output command.
// Depends on rlec_pkg.
module rlec_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                end_of_stream,
	output logic                cmd_push,
	output rlec_pkg::cmd_t      cmd
);

	rlec_pkg::mode_t mode_q;
	logic [7:0] prev_q;
	logic [3:0] repeat_q;
	logic       await_q;
	logic       literal_q;

	logic [7:0] prev_nx;
	logic [3:0] repeat_nx;
	logic       await_nx;
	logic       literal_nx;

	logic       eq;
	logic [3:0] cnt_inc;
	logic [3:0] fl_c;
	logic [1:0] fl_n;
	logic [7:0] fl0;
	logic [7:0] fl1;
	logic       is_digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rlec_pkg::MODE_COMPRESS;
		end else if (cfg_we) begin
			mode_q <= rlec_pkg::mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			repeat_q  <= '0;
			await_q   <= 1'b0;
			literal_q <= 1'b0;
		end else if (accept) begin
			prev_q    <= prev_nx;
			repeat_q  <= repeat_nx;
			await_q   <= await_nx;
			literal_q <= literal_nx;
		end
	end

	assign eq       = (data_byte == prev_q);
	assign cnt_inc  = repeat_q + 4'd1;
	assign is_digit = data_byte inside {[rlec_pkg::DigitZero : rlec_pkg::DigitNine]};

	// Flush of a pending count: one copy for a count of one, escape and digit
	// for two to nine, nothing otherwise
	assign fl_c = eq ? cnt_inc : repeat_q;
	assign fl0  = (fl_c == 4'd1) ? prev_q : rlec_pkg::EscChar;
	assign fl1  = rlec_pkg::DigitZero + {4'd0, fl_c};
	always_comb begin
		if (fl_c == 4'd1) begin
			fl_n = 2'd1;
		end else if (fl_c inside {[4'd2 : 4'd9]}) begin
			fl_n = 2'd2;
		end else begin
			fl_n = 2'd0;
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.kind   = rlec_pkg::CMD_LIST;
		prev_nx    = prev_q;
		repeat_nx  = repeat_q;
		await_nx   = await_q;
		literal_nx = literal_q;

		if (mode_q == rlec_pkg::MODE_COMPRESS) begin
			prev_nx = data_byte;
			if (eq) begin
				if (cnt_inc >= rlec_pkg::RunLimit) begin
					cmd.byte0 = rlec_pkg::EscChar;
					cmd.byte1 = rlec_pkg::DigitZero + {4'd0, rlec_pkg::FullRunDigit};
					cmd.byte2 = data_byte;
					cmd.cnt   = 4'd3;
					repeat_nx = '0;
				end else begin
					repeat_nx = cnt_inc;
					if (end_of_stream) begin
						cmd.byte0 = fl0;
						cmd.byte1 = fl1;
						cmd.cnt   = {2'd0, fl_n};
					end
				end
			end else begin
				repeat_nx = '0;
				case (fl_n)
					2'd1: begin
						cmd.byte0 = fl0;
						cmd.byte1 = data_byte;
						cmd.cnt   = 4'd2;
					end
					2'd2: begin
						cmd.byte0 = fl0;
						cmd.byte1 = fl1;
						cmd.byte2 = data_byte;
						cmd.cnt   = 4'd3;
					end
					default: begin
						cmd.byte0 = data_byte;
						cmd.cnt   = 4'd1;
					end
				endcase
			end
		end else begin
			if (literal_q) begin
				cmd.byte0  = data_byte;
				cmd.cnt    = 4'd1;
				prev_nx    = data_byte;
				literal_nx = 1'b0;
			end else if (await_q) begin
				cmd.kind   = rlec_pkg::CMD_REPEAT;
				cmd.byte0  = prev_q;
				cmd.cnt    = is_digit ? 4'(data_byte - rlec_pkg::DigitZero) : 4'd0;
				await_nx   = 1'b0;
				literal_nx = 1'b1;
			end else if (data_byte == rlec_pkg::EscChar) begin
				await_nx = 1'b1;
			end else begin
				cmd.byte0 = data_byte;
				cmd.cnt   = 4'd1;
				prev_nx   = data_byte;
			end
		end

		// End of stream returns the stream state to its reset value
		if (end_of_stream) begin
			prev_nx    = '0;
			repeat_nx  = '0;
			await_nx   = 1'b0;
			literal_nx = 1'b0;
		end
	end

	// Drop items that produce nothing
	assign cmd_push = accept && (cmd.cnt != 4'd0);

endmodule

FILE: rtl/rlec_queue.sv
// Short command queue between the front and back ends of the codec.
// Depends on rlec_pkg.
module rlec_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rlec_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output logic                full,
	output rlec_pkg::q_head_t   head
);

	rlec_pkg::cmd_t mem_q [rlec_pkg::QDepth];
	logic [rlec_pkg::QAw-1:0]   wptr_q;
	logic [rlec_pkg::QAw-1:0]   rptr_q;
	logic [rlec_pkg::QCntW-1:0] count_q;

	assign full       = (count_q == rlec_pkg::QCntW'(rlec_pkg::QDepth));
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/rlec_back.sv
// Back end of the codec: expands the head command one byte per cycle, unless
// out_stall holds it, into the output register. Depends on rlec_pkg.
module rlec_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rlec_pkg::q_head_t   head,
	output logic                pop,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                run_last
);

	logic [3:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       load;
	logic       last;
	logic [7:0] sel;

	assign load = !valid_q || !out_stall;
	assign last = ((idx_q + 4'd1) == head.cmd.cnt);
	assign pop  = load && head.valid && last;

	always_comb begin
		if (head.cmd.kind == rlec_pkg::CMD_REPEAT) begin
			sel = head.cmd.byte0;
		end else begin
			case (idx_q[1:0])
				2'd0:    sel = head.cmd.byte0;
				2'd1:    sel = head.cmd.byte1;
				default: sel = head.cmd.byte2;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= head.valid;
			if (head.valid) begin
				idx_q <= last ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			byte_q <= sel;
			last_q <= last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign run_last  = last_q;

endmodule

FILE: dv/tb_rle_dollar_escape_codec.sv
`timescale 1ns / 1ps
// Self-checking testbench for rle_dollar_escape_codec: directed and random byte streams
// in both modes, checked against an in-bench byte predictor. Depends on rlec_pkg and the RTL.

// One expected output byte of the coded or decoded stream
typedef struct {
	logic [7:0] value;
	logic       last;
} coded_byte_t;

// Tracks the codec's stream state and holds the bytes it must still produce
class codec_byte_predictor;
	rlec_pkg::mode_t mode;
	logic [7:0]      prev_byte;
	logic [3:0]      run_count;
	bit              awaiting_digit;
	bit              literal_next;
	coded_byte_t     expected_bytes[$];
	int              errors;

	function new();
		mode = rlec_pkg::MODE_COMPRESS;
		clear_stream();
		errors = 0;
	endfunction

	function void clear_stream();
		prev_byte      = 8'h00;
		run_count      = 4'd0;
		awaiting_digit = 1'b0;
		literal_next   = 1'b0;
	endfunction

	function void set_mode(logic value);
		mode = rlec_pkg::mode_t'(value);
	endfunction

	function int pending_count();
		return expected_bytes.size();
	endfunction

	function void push_byte(logic [7:0] value);
		coded_byte_t item;
		item.value = value;
		item.last  = 1'b0;
		expected_bytes.push_back(item);
	endfunction

	// Close a pending run: one repeat as the byte, two to nine as escape and digit
	function void flush_run();
		if (run_count == 4'd1) begin
			push_byte(prev_byte);
		end else if (run_count >= 4'd2 && run_count <= 4'd9) begin
			push_byte(rlec_pkg::EscChar);
			push_byte(rlec_pkg::DigitZero + {4'd0, run_count});
		end
		run_count = 4'd0;
	endfunction

	// Predict the bytes caused by one accepted request
	function void note_request(logic [7:0] data, logic eos);
		int first;
		int digit;
		first = expected_bytes.size();
		if (mode == rlec_pkg::MODE_COMPRESS) begin
			if (data == prev_byte) begin
				run_count = run_count + 4'd1;
				if (run_count >= rlec_pkg::RunLimit) begin
					push_byte(rlec_pkg::EscChar);
					push_byte(rlec_pkg::DigitNine);
					push_byte(data);
					run_count = 4'd0;
				end
			end else begin
				flush_run();
				push_byte(data);
			end
			prev_byte = data;
			if (eos)
				flush_run();
		end else begin
			if (literal_next) begin
				push_byte(data);
				prev_byte    = data;
				literal_next = 1'b0;
			end else if (awaiting_digit) begin
				// a non-digit after the escape counts as zero
				digit = 0;
				if (data >= rlec_pkg::DigitZero && data <= rlec_pkg::DigitNine)
					digit = int'(data - rlec_pkg::DigitZero);
				repeat (digit) push_byte(prev_byte);
				awaiting_digit = 1'b0;
				literal_next   = 1'b1;
			end else if (data == rlec_pkg::EscChar) begin
				awaiting_digit = 1'b1;
			end else begin
				push_byte(data);
				prev_byte = data;
			end
		end
		if (eos)
			clear_stream();
		if (expected_bytes.size() > first)
			expected_bytes[expected_bytes.size() - 1].last = 1'b1;
	endfunction

	task report(string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		errors++;
	endtask

	// Compare one accepted output byte with the oldest expectation
	task check_byte(logic [7:0] value, logic last);
		coded_byte_t want;
		if (expected_bytes.size() == 0) begin
			report($sformatf("unexpected output byte %02h run_last %0b", value, last));
		end else begin
			want = expected_bytes.pop_front();
			if (value !== want.value)
				report($sformatf("out_byte %02h, expected %02h", value, want.value));
			if (last !== want.last)
				report($sformatf("run_last %0b, expected %0b (byte %02h)",
					last, want.last, want.value));
		end
	endtask
endclass

module tb_rle_dollar_escape_codec;

	// Cycles with no handshake at all before the run is declared hung
	localparam int StallLimit = 2000;
	// Cycles to let the block settle after the last expected byte
	localparam int SettleCycles = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_stream = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	codec_byte_predictor predictor;
	int idle_pct = 32;
	int requests_sent = 0;
	int quiet_cycles = 0;

	rle_dollar_escape_codec DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.run_last     (run_last)
	);

	always #5 clk = ~clk;

	// Receiver: stall at random at the rate currently in force
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	// Monitor: sample handshakes with their pre-edge values at each rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				predictor.set_mode(cfg_wdata);
			if (in_valid && in_stall === 1'b0)
				predictor.note_request(data_byte, end_of_stream);
			if (out_valid === 1'b1 && !out_stall)
				predictor.check_byte(out_byte, run_last);
		end
	end

	// Count cycles in which neither channel moves a request
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < StallLimit)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	// Present one request, idling at random first, and hold it until accepted
	task send_req(input logic [7:0] value, input logic eos);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= value;
		end_of_stream <= eos;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		requests_sent++;
	endtask

	task send_run(input logic [7:0] value, input int len, input logic eos_at_end);
		for (int i = 0; i < len; i++)
			send_req(value, eos_at_end && (i == len - 1));
	endtask

	// Drop valid, wait for every expected byte, then let the queue settle
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predictor.pending_count() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Write the mode register; only called with the block idle
	task write_mode(input rlec_pkg::mode_t value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return rlec_pkg::EscChar;
			2: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Runs of random bytes, mostly short, now and then past the run limit
	task compress_phase(input int count);
		int         sent;
		int         len;
		logic [7:0] value;
		sent = 0;
		while (sent < count) begin
			len   = ($urandom_range(5) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4);
			value = pick_byte();
			send_run(value, len, $urandom_range(11) == 0);
			sent += len;
		end
		if ($urandom_range(1))
			send_req(pick_byte(), 1'b1);
	endtask

	// Mostly well-formed coded streams: literals and escape, digit, literal;
	// the rest is noise such as a bad digit or a stray escape
	task decompress_phase(input int count);
		int         sent;
		logic [7:0] value;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					do
						value = pick_byte();
					while (value == rlec_pkg::EscChar);
					send_req(value, $urandom_range(19) == 0);
					sent += 1;
				end
				4, 5, 6, 7: begin
					send_req(rlec_pkg::EscChar, 1'b0);
					send_req(8'($urandom_range(rlec_pkg::DigitZero, rlec_pkg::DigitNine)),
						1'b0);
					send_req(pick_byte(), $urandom_range(9) == 0);
					sent += 3;
				end
				default: begin
					send_req(8'($urandom_range(255)), $urandom_range(9) == 0);
					sent += 1;
				end
			endcase
		end
	endtask

	initial begin
		predictor = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(rlec_pkg::MODE_COMPRESS);

		// Compress: a leading zero counts as a repeat, so two zeros flush as escape and '2'
		send_req(8'h00, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'h41, 1'b0);
		// ten repeats close as escape, '9', byte
		send_run(8'h41, 10, 1'b0);
		// literal escape character passes unescaped
		send_req(rlec_pkg::EscChar, 1'b0);
		// end of stream with one pending repeat flushes the byte itself
		send_req(8'hFF, 1'b0);
		send_req(8'hFF, 1'b1);
		drain();

		write_mode(rlec_pkg::MODE_DECOMPRESS);
		send_req(8'h42, 1'b0);
		send_req(rlec_pkg::EscChar, 1'b0);
		send_req(rlec_pkg::DigitZero + 8'd5, 1'b0);
		// the byte after the digit is a literal even when it is the escape
		send_req(rlec_pkg::EscChar, 1'b0);
		// a non-digit after the escape counts as zero
		send_req(rlec_pkg::EscChar, 1'b0);
		send_req(8'h78, 1'b0);
		send_req(8'h00, 1'b0);
		send_req(rlec_pkg::EscChar, 1'b0);
		send_req(rlec_pkg::DigitNine, 1'b0);
		send_req(8'hFF, 1'b0);
		// end of stream inside an escape abandons it
		send_req(rlec_pkg::EscChar, 1'b1);
		drain();

		// Random phases; mode changes mid-stream keep the stream state
		for (int phase = 0; phase < 8; phase++) begin
			idle_pct = (phase == 3) ? 0 : 32;
			if (phase % 2 == 0) begin
				write_mode(rlec_pkg::MODE_COMPRESS);
				compress_phase(40);
			end else begin
				write_mode(rlec_pkg::MODE_DECOMPRESS);
				decompress_phase(40);
			end
			drain();
		end
		idle_pct = 32;

		if (predictor.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
rtl/rlec_pkg.sv
rtl/rlec_front.sv
rtl/rlec_queue.sv
rtl/rlec_back.sv
rtl/rle_dollar_escape_codec.sv
dv/tb_rle_dollar_escape_codec.sv
